@@ rtl/ssd_pkg.sv @@
package ssd_pkg;

    // Number of digit positions on the display (1 to 8).
    localparam int DIGIT_COUNT = 4;
    localparam int DIG_W       = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [DIG_W-1:0] LAST_DIGIT = DIG_W'(DIGIT_COUNT - 1);

    localparam int VALUE_W = 16;
    localparam int MAG_W   = VALUE_W + 1;
    localparam int FRAME_BITS = 16;
    localparam int FRAME_W    = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

    // x / 10 == (x * 52429) >> 19 holds exactly for every x below 81920.
    localparam logic [MAG_W-1:0] RECIP_TEN   = MAG_W'(52429);
    localparam int               RECIP_SHIFT = 19;

    localparam logic [7:0] SEG_POINT = 8'h80;
    localparam logic [7:0] SEG_MINUS = 8'h40;
    localparam logic [7:0] PAT_ZERO  = 8'h3F;
    localparam int         RESET_POINT = 1;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_DIGIT_ON_LEVEL   = 2'd0,
        REG_SEGMENT_ON_LEVEL = 2'd1,
        REG_POINT_POSITION   = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_SCAN = 1'b1
    } op_t;

    typedef struct packed {
        op_t              op;
        logic             negative;
        logic [MAG_W-1:0] magnitude;
    } item_t;

    typedef struct packed {
        logic digit_on_level;
        logic segment_on_level;
        logic [1:0] point_position;
    } cfg_t;

    function automatic logic [7:0] digit_pattern(input logic [3:0] digit);
        logic [7:0] pat;
        case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = 8'h00;
        endcase
        return pat;
    endfunction

endpackage

@@ rtl/seven_segment_scan_driver.sv @@
// Four-digit multiplexed seven-segment driver for a chained pair of 8-bit shift
// registers. A load item (operation 0) turns a signed 16-bit value into decimal
// digit patterns, one digit per cycle through a shared divide-by-ten
// multiplier; negative values show a minus on the top digit. A scan item
// (operation 1) sends 16 beats, one per cycle when the sink is ready: digit
// select MSB first, then the segment pattern, with latch_after set on the last
// beat. Items enter a two-entry queue, so new items are taken while the engine
// is busy; the engine starts the next item in the cycle the current one ends,
// so a stream of scans runs back to back at one output beat per cycle while the
// sink is ready. Configuration is written over APB at byte offsets 0, 4 and 8.
module seven_segment_scan_driver (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [ssd_pkg::ADDR_W-1:0]     paddr,
    input  logic [ssd_pkg::DATA_W-1:0]     pwdata,
    output logic [ssd_pkg::DATA_W-1:0]     prdata,
    output logic                           pready,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_operation,
    input  logic signed [15:0]             s_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_serial_level,
    output logic                           m_latch_after
);
    import ssd_pkg::*;

    cfg_t                cfg_reg;
    reg_index_t          reg_index;
    logic                cfg_write;
    logic                q_valid;
    item_t               q_item;
    logic                q_ready;
    logic [QCOUNT_W-1:0] q_count;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[ADDR_W-1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.digit_on_level   <= 1'b0;
            cfg_reg.segment_on_level <= 1'b1;
            cfg_reg.point_position   <= 2'(RESET_POINT);
        end else if (cfg_write) begin
            unique case (reg_index)
                REG_DIGIT_ON_LEVEL:   cfg_reg.digit_on_level   <= pwdata[0];
                REG_SEGMENT_ON_LEVEL: cfg_reg.segment_on_level <= pwdata[0];
                REG_POINT_POSITION:   cfg_reg.point_position   <= pwdata[1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            REG_DIGIT_ON_LEVEL:   prdata[0]   = cfg_reg.digit_on_level;
            REG_SEGMENT_ON_LEVEL: prdata[0]   = cfg_reg.segment_on_level;
            REG_POINT_POSITION:   prdata[1:0] = cfg_reg.point_position;
            default: begin
            end
        endcase
    end

    ssd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_value     (s_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_ready     (q_ready),
        .q_count     (q_count)
    );

    ssd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_ready        (q_ready),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_serial_level (m_serial_level),
        .m_latch_after  (m_latch_after)
    );

    // The queue never holds more items than it has entries.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCOUNT_W'(QUEUE_DEPTH))
        else $error("item queue overfilled");

    // A frame has sixteen beats, so two latch beats are never adjacent.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_latch_after) |=> !(m_valid && m_latch_after))
        else $error("latch beat repeated without a full frame");

    // The queue offers no item while it is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == '0) |-> !q_valid)
        else $error("queue offers an item while empty");

endmodule

@@ rtl/ssd_front.sv @@
module ssd_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_operation,
    input  logic signed [15:0]         s_value,
    output logic                       q_valid,
    output ssd_pkg::item_t             q_item,
    input  logic                       q_ready,
    output logic [ssd_pkg::QCOUNT_W-1:0] q_count
);
    import ssd_pkg::*;

    item_t                entry_reg [QUEUE_DEPTH];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [QCOUNT_W-1:0]  count_reg;
    logic [QCOUNT_W-1:0]  count_next;
    item_t                incoming;
    logic                 push;
    logic                 pop;
    logic [VALUE_W-1:0]   raw_bits;

    // The magnitude is formed on 17 bits so that the most negative value stays 32768.
    always_comb begin
        raw_bits           = VALUE_W'(s_value);
        incoming.op        = op_t'(s_operation);
        incoming.negative  = raw_bits[VALUE_W-1];
        if (raw_bits[VALUE_W-1]) begin
            incoming.magnitude = MAG_W'(18'h10000) - {1'b0, raw_bits};
        end else begin
            incoming.magnitude = {1'b0, raw_bits};
        end
    end

    assign s_ready = (count_reg != QCOUNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign q_count = count_reg;
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

@@ rtl/ssd_back.sv @@
module ssd_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  ssd_pkg::cfg_t  cfg,
    input  logic           q_valid,
    input  ssd_pkg::item_t q_item,
    output logic           q_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output logic           m_serial_level,
    output logic           m_latch_after
);
    import ssd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN
    } state_t;

    state_t                state_reg;
    logic [DIG_W-1:0]      dig_cnt_reg;
    logic [FRAME_W-1:0]    bit_cnt_reg;
    logic [DIG_W-1:0]      pos_reg;
    logic                  m_valid_reg;
    logic                  m_serial_reg;
    logic                  m_latch_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic                  neg_reg;
    logic [1:0]            point_reg;
    logic [7:0]            store_reg [DIGIT_COUNT];

    logic [2*MAG_W-1:0]    product;
    logic [MAG_W-1:0]      quotient;
    logic [MAG_W-1:0]      remainder;
    logic [7:0]            load_pat;
    logic [7:0]            scan_pat;
    logic [2:0]            bit_index;
    logic                  scan_bit;
    logic                  last_bit;
    logic                  advance;
    logic                  finishing;
    logic                  take;
    logic [DIG_W-1:0]      pos_next;

    // One decimal digit per cycle: divide by ten through the reciprocal multiply.
    always_comb begin
        product   = mag_reg * RECIP_TEN;
        quotient  = MAG_W'(product >> RECIP_SHIFT);
        remainder = mag_reg - (quotient << 3) - (quotient << 1);
        load_pat  = digit_pattern(remainder[3:0]);
        if (4'(point_reg) == 4'(dig_cnt_reg)) begin
            load_pat = load_pat | SEG_POINT;
        end
        if (neg_reg && dig_cnt_reg == LAST_DIGIT) begin
            load_pat = SEG_MINUS;
        end
    end

    // The frame is read live from the store, so a load just finished is seen at once.
    always_comb begin
        scan_pat  = store_reg[pos_reg];
        bit_index = 3'(7) - bit_cnt_reg[2:0];
        if (!bit_cnt_reg[FRAME_W-1]) begin
            scan_bit = (bit_index == 3'(pos_reg)) ? cfg.digit_on_level
                                                   : ~cfg.digit_on_level;
        end else begin
            scan_bit = scan_pat[bit_index] ? cfg.segment_on_level
                                           : ~cfg.segment_on_level;
        end
        last_bit = (bit_cnt_reg == FRAME_W'(FRAME_BITS - 1));
        pos_next = (pos_reg == LAST_DIGIT) ? '0 : pos_reg + 1'b1;
    end

    assign advance   = !m_valid_reg || m_ready;
    assign finishing = (state_reg == ST_LOAD && dig_cnt_reg == LAST_DIGIT)
                    || (state_reg == ST_SCAN && advance && last_bit);
    assign q_ready   = (state_reg == ST_IDLE) || finishing;
    assign take      = q_valid && q_ready;

    assign m_valid        = m_valid_reg;
    assign m_serial_level = m_serial_reg;
    assign m_latch_after  = m_latch_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            dig_cnt_reg <= '0;
            bit_cnt_reg <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                store_reg[i] <= (i == RESET_POINT) ? (PAT_ZERO | SEG_POINT) : PAT_ZERO;
            end
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    store_reg[dig_cnt_reg] <= load_pat;
                    // On the last digit the counters are left for the next item to set.
                    if (!finishing) begin
                        mag_reg     <= quotient;
                        dig_cnt_reg <= dig_cnt_reg + 1'b1;
                    end
                end
                ST_SCAN: begin
                    if (advance) begin
                        m_serial_reg <= scan_bit;
                        m_latch_reg  <= last_bit;
                        if (last_bit) begin
                            pos_reg <= pos_next;
                        end else begin
                            bit_cnt_reg <= bit_cnt_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (state_reg == ST_SCAN && advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (take) begin
                state_reg   <= (q_item.op == OP_LOAD) ? ST_LOAD : ST_SCAN;
                mag_reg     <= q_item.magnitude;
                neg_reg     <= q_item.negative;
                point_reg   <= cfg.point_position;
                dig_cnt_reg <= '0;
                bit_cnt_reg <= '0;
            end else if (finishing) begin
                state_reg <= ST_IDLE;
            end
        end
    end

endmodule
